/* design/ptri_pkg.sv */
// ----------------------------------------------------------------------------
// ptri_pkg: shared types and constants for planar trilateration
// Status codes, fixed field widths and pipeline depth helpers.
// ----------------------------------------------------------------------------
package ptri_pkg;

  localparam int RANGE_W   = 16;  // range field width
  localparam int POS_W     = 24;  // position field width
  localparam int MUL_CHUNK = 24;  // operand slice width of the wide multiplier

  typedef enum logic [1:0] {
    GEO_OK         = 2'd0,
    GEO_COINCIDENT = 2'd1,
    GEO_COLLINEAR  = 2'd2
  } geo_status_t;

  // quotient magnitude bits kept by the divider; beyond this the sum saturates
  function automatic int div_qbits(input int coord_bits, input int frac_bits);
    return ((coord_bits + frac_bits > POS_W) ? coord_bits + frac_bits : POS_W) + 1;
  endfunction

  // cycles from the accepting edge to the edge that samples out_valid
  function automatic int pipe_latency(input int coord_bits, input int frac_bits);
    return div_qbits(coord_bits, frac_bits) + 15;
  endfunction

endpackage

/* design/ptri_mul.sv */
// ----------------------------------------------------------------------------
// ptri_mul: two-stage signed multiplier for wide operands
// Slices operand a, registers the partial products, then sums them.
// ----------------------------------------------------------------------------
module ptri_mul #(
  parameter int AW = 44,
  parameter int BW = 35
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int CW  = ptri_pkg::MUL_CHUNK;
  localparam int NCH = (AW + CW - 1) / CW;
  localparam int EW  = NCH * CW;
  localparam int PPW = CW + BW + 1;
  localparam int SW  = EW + BW + 1;

  logic signed [EW-1:0]     a_ext;
  logic signed [PPW-1:0]    pp_r [NCH];
  logic signed [SW-1:0]     acc;
  logic signed [AW+BW-1:0]  p_nxt;
  logic signed [AW+BW-1:0]  p_r;

  assign a_ext = EW'(a);

  // low slices are unsigned, the top slice carries the sign
  always_ff @(posedge clk) begin
    for (int k = 0; k < NCH; k++) begin
      if (k == NCH - 1) begin
        pp_r[k] <= PPW'($signed(a_ext[k*CW +: CW])) * PPW'(b);
      end else begin
        pp_r[k] <= PPW'($signed({1'b0, a_ext[k*CW +: CW]})) * PPW'(b);
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < NCH; k++) begin
      acc = acc + (SW'(pp_r[k]) <<< (k * CW));
    end
    p_nxt = acc[AW+BW-1:0];
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p = p_r;

endmodule

/* design/ptri_div.sv */
// ----------------------------------------------------------------------------
// ptri_div: pipelined floor divider for both position lanes
// One quotient bit per stage, then floor fix-up, offset add and saturation.
// ----------------------------------------------------------------------------
module ptri_div #(
  parameter int NUMW = 100,
  parameter int DENW = 75,
  parameter int OW   = 20,
  parameter int QB   = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [NUMW-1:0]        num_x,
  input  logic signed [NUMW-1:0]        num_y,
  input  logic [DENW-1:0]               den,
  input  logic signed [OW-1:0]          off_x,
  input  logic signed [OW-1:0]          off_y,
  input  ptri_pkg::geo_status_t         tag_in,
  output logic                          out_valid,
  output logic signed [ptri_pkg::POS_W-1:0] pos_x,
  output logic signed [ptri_pkg::POS_W-1:0] pos_y,
  output ptri_pkg::geo_status_t         tag_out
);

  localparam int PW_O = ptri_pkg::POS_W;
  localparam int RW   = DENW + 1;
  localparam int QW   = QB + 2;
  localparam int SW   = ((QW > OW) ? QW : OW) + 1;

  logic signed [NUMW-1:0] num_in [2];
  logic signed [OW-1:0]   off_in [2];

  assign num_in[0] = num_x;
  assign num_in[1] = num_y;
  assign off_in[0] = off_x;
  assign off_in[1] = off_y;

  // stage a: sign and magnitude
  logic                  va_r;
  ptri_pkg::geo_status_t taga_r;
  logic [DENW-1:0]       dena_r;
  logic                  sgna_r [2];
  logic [NUMW-1:0]       maga_r [2];
  logic signed [OW-1:0]  offa_r [2];

  // stage b (index 0) and quotient bit stages
  logic                  vi_r   [QB+1];
  ptri_pkg::geo_status_t tagi_r [QB+1];
  logic [DENW-1:0]       deni_r [QB+1];
  logic                  sgni_r [2][QB+1];
  logic                  ovfi_r [2][QB+1];
  logic [RW-1:0]         remi_r [2][QB+1];
  logic [QB-1:0]         loi_r  [2][QB+1];
  logic [QB-1:0]         qi_r   [2][QB+1];
  logic signed [OW-1:0]  offi_r [2][QB+1];

  // fix-up stages
  logic                  vf_r;
  ptri_pkg::geo_status_t tagf_r;
  logic signed [QW-1:0]  qs_r   [2];
  logic signed [QW-1:0]  qs_nxt [2];
  logic signed [OW-1:0]  offf_r [2];

  logic                  vo_r;
  ptri_pkg::geo_status_t tago_r;
  logic signed [PW_O-1:0] pos_r   [2];
  logic signed [PW_O-1:0] pos_nxt [2];
  logic signed [SW-1:0]   sum     [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vf_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vf_r <= vi_r[QB];
      vo_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vi_r[0] <= 1'b0;
    end else begin
      vi_r[0] <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    taga_r    <= tag_in;
    dena_r    <= den;
    tagi_r[0] <= taga_r;
    deni_r[0] <= dena_r;
    for (int l = 0; l < 2; l++) begin
      sgna_r[l] <= num_in[l][NUMW-1];
      maga_r[l] <= num_in[l][NUMW-1] ? NUMW'(-num_in[l]) : NUMW'(num_in[l]);
      offa_r[l] <= off_in[l];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane0
    always_ff @(posedge clk) begin
      sgni_r[l][0] <= sgna_r[l];
      ovfi_r[l][0] <= (maga_r[l] >> QB) >= NUMW'(dena_r);
      remi_r[l][0] <= RW'(maga_r[l] >> QB);
      loi_r[l][0]  <= maga_r[l][QB-1:0];
      qi_r[l][0]   <= '0;
      offi_r[l][0] <= offa_r[l];
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_bit
    logic [RW-1:0] trial [2];
    logic          fits  [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = {remi_r[l][k][RW-2:0], loi_r[l][k][QB-1-k]};
        fits[l]  = trial[l] >= RW'(deni_r[k]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vi_r[k+1] <= 1'b0;
      end else begin
        vi_r[k+1] <= vi_r[k];
      end
    end

    always_ff @(posedge clk) begin
      tagi_r[k+1] <= tagi_r[k];
      deni_r[k+1] <= deni_r[k];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      always_ff @(posedge clk) begin
        sgni_r[l][k+1] <= sgni_r[l][k];
        ovfi_r[l][k+1] <= ovfi_r[l][k];
        loi_r[l][k+1]  <= loi_r[l][k];
        offi_r[l][k+1] <= offi_r[l][k];
        remi_r[l][k+1] <= fits[l] ? trial[l] - RW'(deni_r[k]) : trial[l];
        qi_r[l][k+1]   <= qi_r[l][k] | (fits[l] ? (QB'(1) << (QB - 1 - k)) : '0);
      end
    end
  end

  // floor: a negative quotient with remainder rounds one further down
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (ovfi_r[l][QB]) begin
        qs_nxt[l] = sgni_r[l][QB] ? -(QW'(1) << QB) - QW'(1) : (QW'(1) << QB);
      end else if (sgni_r[l][QB]) begin
        qs_nxt[l] = -(QW'(qi_r[l][QB]) + QW'(remi_r[l][QB] != '0));
      end else begin
        qs_nxt[l] = QW'(qi_r[l][QB]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sum[l] = SW'(qs_r[l]) + SW'(offf_r[l]);
      if ((&sum[l][SW-1:PW_O-1]) || !(|sum[l][SW-1:PW_O-1])) begin
        pos_nxt[l] = sum[l][PW_O-1:0];
      end else if (sum[l][SW-1]) begin
        pos_nxt[l] = {1'b1, {(PW_O-1){1'b0}}};
      end else begin
        pos_nxt[l] = {1'b0, {(PW_O-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    tagf_r <= tagi_r[QB];
    tago_r <= tagf_r;
    for (int l = 0; l < 2; l++) begin
      qs_r[l]   <= qs_nxt[l];
      offf_r[l] <= offi_r[l][QB];
      pos_r[l]  <= pos_nxt[l];
    end
  end

  assign out_valid = vo_r;
  assign pos_x     = pos_r[0];
  assign pos_y     = pos_r[1];
  assign tag_out   = tago_r;

endmodule

/* design/planar_trilateration.sv */
// ----------------------------------------------------------------------------
// planar_trilateration: position from three anchors and three ranges
// Exact rational solve of the local-frame trilateration, rounded once.
// ----------------------------------------------------------------------------
//
//  channel  | ports                              | handshake
//  ---------+------------------------------------+-------------------------
//  input    | in_anchor1_x .. in_range3          | start & !busy
//  result   | out_pos_x, out_pos_y, out_geometry_status | out_valid strobe
//
//  An item can enter on every cycle; busy never rises.
//  Each accepted item passes the one-bit-per-stage divider (div_qbits
//  stages) plus 15 stages of products, sums and fix-up before out_valid.
//  rst_n clears only the valid bits; data registers carry no reset.
//  Results cannot be held off, so the pipeline never stalls.
//
// Math (offsets from anchor 1: d = P2-P1, a = P3-P1):
//   D = |d|^2, c = d x a, K = r1^2-r2^2+D, L = r1^2-r3^2+|a|^2
//   M = L*D - (d.a)*K
//   pos = P1 + floor((N + h) / 2h), h = |c|*D << F, N = K*c*d + M*perp(d)
// ----------------------------------------------------------------------------
module planar_trilateration #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [COORD_BITS-1:0]           in_anchor1_x,
  input  logic signed [COORD_BITS-1:0]           in_anchor1_y,
  input  logic signed [COORD_BITS-1:0]           in_anchor2_x,
  input  logic signed [COORD_BITS-1:0]           in_anchor2_y,
  input  logic signed [COORD_BITS-1:0]           in_anchor3_x,
  input  logic signed [COORD_BITS-1:0]           in_anchor3_y,
  input  logic [ptri_pkg::RANGE_W-1:0]           in_range1,
  input  logic [ptri_pkg::RANGE_W-1:0]           in_range2,
  input  logic [ptri_pkg::RANGE_W-1:0]           in_range3,
  output logic                                   out_valid,
  output logic signed [ptri_pkg::POS_W-1:0]      out_pos_x,
  output logic signed [ptri_pkg::POS_W-1:0]      out_pos_y,
  output ptri_pkg::geo_status_t                  out_geometry_status
);

  localparam int DW   = COORD_BITS + 1;                 // anchor offsets
  localparam int PW   = 2 * COORD_BITS + 3;             // D, c, d.a, |a|^2
  localparam int SQW  = 2 * ptri_pkg::RANGE_W;          // squared range
  localparam int RSW  = SQW + 1;                        // range-square difference
  localparam int KW   = ((PW + 2 * FRAC_BITS > RSW) ? PW + 2 * FRAC_BITS : RSW) + 1;
  localparam int KCW  = KW + PW;                        // K*c
  localparam int MW   = KW + PW + 1;                    // M
  localparam int NW   = MW + DW + 1;                    // N
  localparam int HW   = 2 * PW + FRAC_BITS;             // h
  localparam int DENW = HW + 1;                         // 2h
  localparam int NUMW = ((NW > HW) ? NW : HW) + 2;      // N + h
  localparam int OW   = COORD_BITS + FRAC_BITS;         // anchor 1 in output scale
  localparam int QB   = ptri_pkg::div_qbits(COORD_BITS, FRAC_BITS);

  assign busy = 1'b0;

  // valid bits and side data, indexed by stage
  logic                  v_r     [1:10];
  logic signed [OW-1:0]  offx_r  [1:10];
  logic signed [OW-1:0]  offy_r  [1:10];
  logic signed [DW-1:0]  dx_r    [1:6];
  logic signed [DW-1:0]  dy_r    [1:6];
  ptri_pkg::geo_status_t stat_r  [3:10];
  logic                  crneg_r [3:9];
  logic signed [HW-1:0]  h_r     [6:9];

  // stage 1
  logic signed [DW-1:0]  ax1_r, ay1_r;
  logic [SQW-1:0]        q1_r, q2_r, q3_r;
  // stage 2
  logic signed [PW-1:0]  dd2_r, cr2_r, dt2_r, aa2_r;
  logic signed [RSW-1:0] kd2_r, ld2_r;
  // stage 3
  logic signed [KW-1:0]  kk3_r, ll3_r;
  logic signed [PW-1:0]  dd3_r, dt3_r, cr3_r, crabs3_r;
  // first product bank, stage 5
  logic signed [KW+PW-1:0] lldd_w, dtkk_w, kkcr_w;
  logic signed [2*PW-1:0]  crdd_w;
  // stage 6
  logic signed [MW-1:0]  mm6_r;
  logic signed [KCW-1:0] kc6_r;
  // second product bank, stage 8
  logic signed [KCW+DW-1:0] kcdx_w, kcdy_w;
  logic signed [MW+DW-1:0]  mmdx_w, mmdy_w;
  // stage 9, 10
  logic signed [NW-1:0]   nx9_r, ny9_r;
  logic signed [NUMW-1:0] numx10_r, numy10_r;
  logic [DENW-1:0]        den10_r;

  // divider outputs and result register
  logic                           dv_w;
  logic signed [ptri_pkg::POS_W-1:0] dpx_w, dpy_w;
  ptri_pkg::geo_status_t          dtag_w;
  logic                           outv_r;
  logic signed [ptri_pkg::POS_W-1:0] outx_r, outy_r;
  ptri_pkg::geo_status_t          outs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 10; k++) begin
        v_r[k] <= 1'b0;
      end
      outv_r <= 1'b0;
    end else begin
      v_r[1] <= start & ~busy;
      for (int k = 2; k <= 10; k++) begin
        v_r[k] <= v_r[k-1];
      end
      outv_r <= dv_w;
    end
  end

  // anchor 1 offset shift line
  always_ff @(posedge clk) begin
    offx_r[1] <= OW'(in_anchor1_x) <<< FRAC_BITS;
    offy_r[1] <= OW'(in_anchor1_y) <<< FRAC_BITS;
    for (int k = 2; k <= 10; k++) begin
      offx_r[k] <= offx_r[k-1];
      offy_r[k] <= offy_r[k-1];
    end
  end

  // stage 1: offsets from anchor 1, squared ranges
  always_ff @(posedge clk) begin
    dx_r[1] <= DW'(in_anchor2_x) - DW'(in_anchor1_x);
    dy_r[1] <= DW'(in_anchor2_y) - DW'(in_anchor1_y);
    for (int k = 2; k <= 6; k++) begin
      dx_r[k] <= dx_r[k-1];
      dy_r[k] <= dy_r[k-1];
    end
    ax1_r   <= DW'(in_anchor3_x) - DW'(in_anchor1_x);
    ay1_r   <= DW'(in_anchor3_y) - DW'(in_anchor1_y);
    q1_r    <= SQW'(in_range1) * SQW'(in_range1);
    q2_r    <= SQW'(in_range2) * SQW'(in_range2);
    q3_r    <= SQW'(in_range3) * SQW'(in_range3);
  end

  // stage 2: norms, cross and dot products
  always_ff @(posedge clk) begin
    dd2_r <= PW'(dx_r[1] * dx_r[1]) + PW'(dy_r[1] * dy_r[1]);
    aa2_r <= PW'(ax1_r * ax1_r) + PW'(ay1_r * ay1_r);
    cr2_r <= PW'(dx_r[1] * ay1_r) - PW'(dy_r[1] * ax1_r);
    dt2_r <= PW'(dx_r[1] * ax1_r) + PW'(dy_r[1] * ay1_r);
    kd2_r <= RSW'(q1_r) - RSW'(q2_r);
    ld2_r <= RSW'(q1_r) - RSW'(q3_r);
  end

  // stage 3: K, L, |c| and the geometry check (coincidence wins)
  always_ff @(posedge clk) begin
    kk3_r      <= KW'(kd2_r) + (KW'(dd2_r) <<< (2 * FRAC_BITS));
    ll3_r      <= KW'(ld2_r) + (KW'(aa2_r) <<< (2 * FRAC_BITS));
    dd3_r      <= dd2_r;
    dt3_r      <= dt2_r;
    cr3_r      <= cr2_r;
    crabs3_r   <= cr2_r[PW-1] ? -cr2_r : cr2_r;
    crneg_r[3] <= cr2_r[PW-1];
    if (dd2_r == '0) begin
      stat_r[3] <= ptri_pkg::GEO_COINCIDENT;
    end else if (cr2_r == '0) begin
      stat_r[3] <= ptri_pkg::GEO_COLLINEAR;
    end else begin
      stat_r[3] <= ptri_pkg::GEO_OK;
    end
    for (int k = 4; k <= 10; k++) begin
      stat_r[k] <= stat_r[k-1];
    end
    for (int k = 4; k <= 9; k++) begin
      crneg_r[k] <= crneg_r[k-1];
    end
  end

  // stages 4-5: first product bank
  ptri_mul #(.AW(KW), .BW(PW)) u_mul_lldd (.clk(clk), .a(ll3_r),    .b(dd3_r), .p(lldd_w));
  ptri_mul #(.AW(KW), .BW(PW)) u_mul_dtkk (.clk(clk), .a(kk3_r),    .b(dt3_r), .p(dtkk_w));
  ptri_mul #(.AW(KW), .BW(PW)) u_mul_kkcr (.clk(clk), .a(kk3_r),    .b(cr3_r), .p(kkcr_w));
  ptri_mul #(.AW(PW), .BW(PW)) u_mul_crdd (.clk(clk), .a(crabs3_r), .b(dd3_r), .p(crdd_w));

  // stage 6: M, K*c, h
  always_ff @(posedge clk) begin
    mm6_r  <= MW'(lldd_w) - MW'(dtkk_w);
    kc6_r  <= kkcr_w;
    h_r[6] <= HW'(crdd_w) <<< FRAC_BITS;
    for (int k = 7; k <= 9; k++) begin
      h_r[k] <= h_r[k-1];
    end
  end

  // stages 7-8: second product bank
  ptri_mul #(.AW(KCW), .BW(DW)) u_mul_kcdx (.clk(clk), .a(kc6_r), .b(dx_r[6]), .p(kcdx_w));
  ptri_mul #(.AW(KCW), .BW(DW)) u_mul_kcdy (.clk(clk), .a(kc6_r), .b(dy_r[6]), .p(kcdy_w));
  ptri_mul #(.AW(MW),  .BW(DW)) u_mul_mmdx (.clk(clk), .a(mm6_r), .b(dx_r[6]), .p(mmdx_w));
  ptri_mul #(.AW(MW),  .BW(DW)) u_mul_mmdy (.clk(clk), .a(mm6_r), .b(dy_r[6]), .p(mmdy_w));

  // stage 9: numerators
  always_ff @(posedge clk) begin
    nx9_r <= NW'(kcdx_w) - NW'(mmdy_w);
    ny9_r <= NW'(kcdy_w) + NW'(mmdx_w);
  end

  // stage 10: fold the sign of c into the numerator, add h for rounding
  always_ff @(posedge clk) begin
    numx10_r <= NUMW'(h_r[9]) + (crneg_r[9] ? -NUMW'(nx9_r) : NUMW'(nx9_r));
    numy10_r <= NUMW'(h_r[9]) + (crneg_r[9] ? -NUMW'(ny9_r) : NUMW'(ny9_r));
    den10_r  <= DENW'(h_r[9]) << 1;
  end

  ptri_div #(
    .NUMW (NUMW),
    .DENW (DENW),
    .OW   (OW),
    .QB   (QB)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r[10]),
    .num_x     (numx10_r),
    .num_y     (numy10_r),
    .den       (den10_r),
    .off_x     (offx_r[10]),
    .off_y     (offy_r[10]),
    .tag_in    (stat_r[10]),
    .out_valid (dv_w),
    .pos_x     (dpx_w),
    .pos_y     (dpy_w),
    .tag_out   (dtag_w)
  );

  // result register: degenerate geometry reports a zero position
  always_ff @(posedge clk) begin
    outx_r <= (dtag_w == ptri_pkg::GEO_OK) ? dpx_w : '0;
    outy_r <= (dtag_w == ptri_pkg::GEO_OK) ? dpy_w : '0;
    outs_r <= dtag_w;
  end

  assign out_valid           = outv_r;
  assign out_pos_x           = outx_r;
  assign out_pos_y           = outy_r;
  assign out_geometry_status = outs_r;

endmodule

/* design/ptri_chk.sv */
// ----------------------------------------------------------------------------
// ptri_chk: port-level checks for planar_trilateration
// Latency, degenerate-geometry reporting; bound to the top level.
// ----------------------------------------------------------------------------
module ptri_chk #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 4
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [COORD_BITS-1:0]             in_anchor1_x,
  input logic [COORD_BITS-1:0]             in_anchor1_y,
  input logic [COORD_BITS-1:0]             in_anchor2_x,
  input logic [COORD_BITS-1:0]             in_anchor2_y,
  input logic                              out_valid,
  input logic [ptri_pkg::POS_W-1:0]        out_pos_x,
  input logic [ptri_pkg::POS_W-1:0]        out_pos_y,
  input ptri_pkg::geo_status_t             out_geometry_status
);

  localparam int LAT = ptri_pkg::pipe_latency(COORD_BITS, FRAC_BITS);

  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_valid)
    else $error("accepted item gave no result");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without an accepted item");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_geometry_status != ptri_pkg::GEO_OK |->
      out_pos_x == '0 && out_pos_y == '0)
    else $error("flagged result with nonzero position");

  a_coincident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(start && !busy && in_anchor1_x == in_anchor2_x &&
                       in_anchor1_y == in_anchor2_y, LAT) |->
      out_geometry_status == ptri_pkg::GEO_COINCIDENT)
    else $error("coincident anchors not flagged");

endmodule

bind planar_trilateration ptri_chk #(
  .COORD_BITS (COORD_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_ptri_chk (.*);

/* tb/sv/ptri_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptri_checker: result predictor and scoreboard for planar_trilateration
// Watches the input and result channels, solves each accepted item exactly
// in wide integer arithmetic and compares results in order.
// ----------------------------------------------------------------------------
module ptri_checker #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic signed [COORD_BITS-1:0]         in_anchor1_x,
  input  logic signed [COORD_BITS-1:0]         in_anchor1_y,
  input  logic signed [COORD_BITS-1:0]         in_anchor2_x,
  input  logic signed [COORD_BITS-1:0]         in_anchor2_y,
  input  logic signed [COORD_BITS-1:0]         in_anchor3_x,
  input  logic signed [COORD_BITS-1:0]         in_anchor3_y,
  input  logic [ptri_pkg::RANGE_W-1:0]         in_range1,
  input  logic [ptri_pkg::RANGE_W-1:0]         in_range2,
  input  logic [ptri_pkg::RANGE_W-1:0]         in_range3,
  input  logic                                 out_valid,
  input  logic signed [ptri_pkg::POS_W-1:0]    out_pos_x,
  input  logic signed [ptri_pkg::POS_W-1:0]    out_pos_y,
  input  ptri_pkg::geo_status_t                out_geometry_status,
  output int                                   errors,
  output int                                   pending
);

  localparam int POS_W = ptri_pkg::POS_W;

  typedef logic signed [255:0] wint_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    ptri_pkg::geo_status_t   status;
  } fix_t;

  fix_t fix_q[$];

  assign pending = fix_q.size();

  function automatic wint_t floor_div(input wint_t num, input wint_t den);
    wint_t q;
    q = num / den;
    if (num < 0 && (num % den) != 0) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_pos(input wint_t v);
    wint_t hi, lo;
    hi = (wint_t'(1) <<< (POS_W - 1)) - 1;
    lo = -(wint_t'(1) <<< (POS_W - 1));
    if (v > hi) return hi[POS_W-1:0];
    if (v < lo) return lo[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

  function automatic fix_t solve_fix();
    fix_t f;
    wint_t x1, y1, dx, dy, ax, ay, q1, q2, q3, dd, cr, dt, aa;
    wint_t kk, ll, mm, kc, nx, ny, h, den;
    x1 = in_anchor1_x;
    y1 = in_anchor1_y;
    dx = wint_t'(in_anchor2_x) - x1;
    dy = wint_t'(in_anchor2_y) - y1;
    ax = wint_t'(in_anchor3_x) - x1;
    ay = wint_t'(in_anchor3_y) - y1;
    q1 = wint_t'({1'b0, in_range1}) * wint_t'({1'b0, in_range1});
    q2 = wint_t'({1'b0, in_range2}) * wint_t'({1'b0, in_range2});
    q3 = wint_t'({1'b0, in_range3}) * wint_t'({1'b0, in_range3});
    dd = dx * dx + dy * dy;
    cr = dx * ay - dy * ax;
    dt = dx * ax + dy * ay;
    aa = ax * ax + ay * ay;
    f.pos_x = '0;
    f.pos_y = '0;
    if (dd == 0) begin
      f.status = ptri_pkg::GEO_COINCIDENT;
      return f;
    end
    if (cr == 0) begin
      f.status = ptri_pkg::GEO_COLLINEAR;
      return f;
    end
    kk = q1 - q2 + (dd <<< (2 * FRAC_BITS));
    ll = q1 - q3 + (aa <<< (2 * FRAC_BITS));
    mm = ll * dd - dt * kk;
    kc = kk * cr;
    nx = kc * dx - mm * dy;
    ny = kc * dy + mm * dx;
    if (cr < 0) begin
      nx = -nx;
      ny = -ny;
      cr = -cr;
    end
    h   = (cr * dd) <<< FRAC_BITS;
    den = h + h;
    f.pos_x  = clamp_pos(floor_div(nx + h, den) + (x1 <<< FRAC_BITS));
    f.pos_y  = clamp_pos(floor_div(ny + h, den) + (y1 <<< FRAC_BITS));
    f.status = ptri_pkg::GEO_OK;
    return f;
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    fix_t want;
    if (rst_n && start && !busy) fix_q.push_back(solve_fix());
    if (rst_n && out_valid) begin
      if (fix_q.size() == 0) begin
        errors = errors + 1;
        $display("%0t: unexpected result x=%0d y=%0d status=%0d", $time,
                 out_pos_x, out_pos_y, out_geometry_status);
      end else begin
        want = fix_q.pop_front();
        if (out_pos_x !== want.pos_x) begin
          errors = errors + 1;
          $display("%0t: pos_x expected %0d actual %0d", $time, want.pos_x, out_pos_x);
        end
        if (out_pos_y !== want.pos_y) begin
          errors = errors + 1;
          $display("%0t: pos_y expected %0d actual %0d", $time, want.pos_y, out_pos_y);
        end
        if (out_geometry_status !== want.status) begin
          errors = errors + 1;
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_geometry_status);
        end
      end
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for planar_trilateration
// Drives directed anchor sets (extremes, coincident and collinear anchors,
// saturating ranges) and then bursts of random items, mostly consistent
// geometry with noisy ranges. ptri_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;

  localparam int CB       = 16;
  localparam int FB       = 4;
  localparam int RW       = ptri_pkg::RANGE_W;
  localparam int N_RANDOM = 1700;
  localparam int DRAIN    = ptri_pkg::pipe_latency(CB, FB) + 10;
  localparam int WD_LIMIT = 4 * ptri_pkg::pipe_latency(CB, FB) + 200;  // idle cycles

  logic                 clk, rst_n, start, busy, out_valid;
  logic signed [CB-1:0] ax1, ay1, ax2, ay2, ax3, ay3;
  logic [RW-1:0]        rg1, rg2, rg3;
  logic signed [ptri_pkg::POS_W-1:0] out_pos_x, out_pos_y;
  ptri_pkg::geo_status_t out_geometry_status;
  int                   errors, pending, idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  planar_trilateration #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_anchor1_x(ax1), .in_anchor1_y(ay1), .in_anchor2_x(ax2), .in_anchor2_y(ay2),
    .in_anchor3_x(ax3), .in_anchor3_y(ay3),
    .in_range1(rg1), .in_range2(rg2), .in_range3(rg3),
    .out_valid(out_valid), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_geometry_status(out_geometry_status)
  );

  ptri_checker #(.COORD_BITS(CB), .FRAC_BITS(FB)) chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_anchor1_x(ax1), .in_anchor1_y(ay1), .in_anchor2_x(ax2), .in_anchor2_y(ay2),
    .in_anchor3_x(ax3), .in_anchor3_y(ay3),
    .in_range1(rg1), .in_range2(rg2), .in_range3(rg3),
    .out_valid(out_valid), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_geometry_status(out_geometry_status),
    .errors(errors), .pending(pending)
  );

  // Watchdog: cycles with neither an accepted item nor a result.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one item from this falling edge on and hold it until accepted.
  // busy only moves on rising edges, so its value here is what the edge sees.
  task automatic send_item(input int x1, y1, x2, y2, x3, y3, r1, r2, r3);
    start = 1'b1;
    ax1 = x1[CB-1:0]; ay1 = y1[CB-1:0]; ax2 = x2[CB-1:0];
    ay2 = y2[CB-1:0]; ax3 = x3[CB-1:0]; ay3 = y3[CB-1:0];
    rg1 = r1[RW-1:0]; rg2 = r2[RW-1:0]; rg3 = r3[RW-1:0];
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // Idle with junk on the data ports so only start gates acceptance.
  task automatic idle_gap(input int n);
    repeat (n) begin
      start = 1'b0;
      {ax1, ay1, ax2, ay2} = {$urandom, $urandom};
      {ax3, ay3, rg1} = 48'({$urandom, $urandom});
      {rg2, rg3} = $urandom;
      @(negedge clk);
    end
  endtask

  // Range in 1/16 units from a true point to an anchor, clipped to 16 bits.
  function automatic int range_to(input int px, py, qx, qy);
    real d;
    int  r;
    d = $sqrt(real'((px - qx) * (px - qx) + (py - qy) * (py - qy))) * 16.0;
    r = int'(d) + $urandom_range(0, 40) - 20;
    if (r < 0) r = 0;
    if (r > 65535) r = 65535;
    return r;
  endfunction

  task automatic random_item();
    int kind, span, x1, y1, x2, y2, x3, y3, px, py, t;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      // raw noise over the full field ranges
      send_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom);
    end else begin
      span = (kind < 60) ? 200 : 1200;
      x1 = $urandom_range(0, 2 * span) - span;  y1 = $urandom_range(0, 2 * span) - span;
      x2 = $urandom_range(0, 2 * span) - span;  y2 = $urandom_range(0, 2 * span) - span;
      x3 = $urandom_range(0, 2 * span) - span;  y3 = $urandom_range(0, 2 * span) - span;
      px = $urandom_range(0, 2 * span) - span;  py = $urandom_range(0, 2 * span) - span;
      if (kind < 24) begin
        x2 = x1; y2 = y1;                         // coincident first pair
      end else if (kind < 28) begin
        t = $urandom_range(0, 6) - 3;             // third anchor on the line
        x3 = x1 + t * (x2 - x1); y3 = y1 + t * (y2 - y1);
      end
      send_item(x1, y1, x2, y2, x3, y3, range_to(px, py, x1, y1),
                range_to(px, py, x2, y2), range_to(px, py, x3, y3));
    end
  endtask

  initial begin
    int sent, burst;
    rst_n = 1'b0;
    start = 1'b0;
    {ax1, ay1, ax2, ay2, ax3, ay3, rg1, rg2, rg3} = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, coincident and collinear anchors, saturation
    send_item(0, 0, 0, 0, 0, 0, 0, 0, 0);                       // all coincide
    send_item(-32768, 32767, -32768, 32767, 5, 5, 65535, 1, 2); // coincident extremes
    send_item(0, 0, 10, 0, 20, 0, 80, 80, 160);                 // collinear on x
    send_item(-32768, -32768, 0, 0, 32767, 32767, 65535, 65535, 65535); // collinear diag
    send_item(0, 0, 10, 0, 0, 10, 80, 80, 80);                  // exact fix
    send_item(0, 0, 3, 0, 0, 4, 0, 48, 64);                     // point on anchor 1
    send_item(100, 100, 110, 100, 100, 90, 0, 160, 160);        // clockwise third
    send_item(-32768, -32768, 32767, -32768, -32768, 32767, 65535, 0, 0);
    send_item(32767, 32767, -32768, 32767, 32767, -32768, 0, 65535, 65535);
    send_item(0, 0, 1, 0, 0, 1, 65535, 0, 0);                   // saturates high
    send_item(0, 0, 1, 0, 0, 1, 0, 65535, 65535);               // saturates low
    send_item(-32768, 32767, 32767, -32768, 32767, 32767, 65535, 65535, 0);
    send_item(32767, -32768, -32768, 32767, -32768, -32768, 1, 1, 1);
    send_item(0, 0, 1, 1, 1, 0, 65535, 65535, 65535);
    send_item(5, 5, 6, 5, 5, 6, 16, 23, 23);                    // rounding near halves
    send_item(-1, -1, 1, -1, -1, 1, 8, 24, 24);
    idle_gap(3);

    // random bursts with gaps of random length, some bursts back to back
    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 40);
      repeat (burst) random_item();
      sent += burst;
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    start = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ptri_pkg.sv
design/ptri_mul.sv
design/ptri_div.sv
design/planar_trilateration.sv
design/ptri_chk.sv
tb/sv/ptri_checker.sv
tb/sv/tb.sv
